// ===== design/q2e_pkg.sv =====
// shared constants, types and helpers for the quaternion to euler unit
package q2e_pkg;

    // cordic angle accumulator width, pi = 2^31
    localparam int ACC_W = 32;
    // datapath width for cordic x/y, covers growth of 30-bit fraction terms
    localparam int DAT_W = 36;

    typedef logic [ACC_W-1:0]        t_angle;
    typedef logic signed [DAT_W-1:0] t_dat;

    // one cordic lane moving down the chain
    typedef struct packed {
        t_dat   x;
        t_dat   y;
        t_angle acc;
    } t_lane;

    // atan(2^-i), pi = 2^31
    function automatic t_angle atan_lut(input logic [4:0] idx);
        t_angle v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // round half up to a 16-bit binary angle
    function automatic logic [15:0] to_out(input t_angle acc);
        t_angle t;
        t = acc + 32'h0000_8000;
        return t[31:16];
    endfunction

endpackage

// ===== design/q2e_cordic_cell.sv =====
// one vectoring cordic micro-rotation cell for three lanes
module q2e_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  q2e_pkg::t_lane i_lane [3],
    input  logic [15:0]    i_side,
    output logic           o_vld,
    output q2e_pkg::t_lane o_lane [3],
    output logic [15:0]    o_side
);

    localparam int SH = STEP;

    logic           r_vld;
    q2e_pkg::t_lane r_lane [3];
    logic [15:0]    r_side;
    q2e_pkg::t_lane n_lane [3];

    // rotate each lane toward the x axis
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!i_lane[k].y[q2e_pkg::DAT_W-1]) begin
                n_lane[k].x   = i_lane[k].x + (i_lane[k].y >>> SH);
                n_lane[k].y   = i_lane[k].y - (i_lane[k].x >>> SH);
                n_lane[k].acc = i_lane[k].acc + q2e_pkg::atan_lut(5'(STEP));
            end else begin
                n_lane[k].x   = i_lane[k].x - (i_lane[k].y >>> SH);
                n_lane[k].y   = i_lane[k].y + (i_lane[k].x >>> SH);
                n_lane[k].acc = i_lane[k].acc - q2e_pkg::atan_lut(5'(STEP));
            end
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
        r_side <= i_side;
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;
    assign o_side = r_side;

endmodule

// ===== design/q2e_front.sv =====
// front end: products, sum terms, clamp test and pitch square root
module q2e_front #(
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic signed [15:0] i_w,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_z,
    output logic               o_vld,
    output q2e_pkg::t_lane     o_lane [3],
    output logic [15:0]        o_side
);

    localparam int TWO_F = 2 * FRAC_BITS;
    localparam int RED   = (TWO_F > 30) ? TWO_F - 30 : 0;
    localparam int G     = TWO_F - RED;
    localparam int PW    = (TWO_F + 3 > 36) ? TWO_F + 3 : 36;
    localparam int SQW   = 2 * G + 2;
    localparam int RW    = G + 1;
    localparam int NSQ   = RW;
    localparam int STG   = (NSQ + 3) / 4;

    typedef logic signed [PW-1:0] t_wide;
    typedef logic [SQW-1:0]       t_sq;

    // stage 1: products
    logic  r1_vld;
    t_wide r1_wx, r1_yz, r1_xx, r1_yy, r1_wz, r1_xy, r1_zz, r1_wy, r1_zx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_wx <= PW'(i_w * i_x);
        r1_yz <= PW'(i_y * i_z);
        r1_xx <= PW'(i_x * i_x);
        r1_yy <= PW'(i_y * i_y);
        r1_wz <= PW'(i_w * i_z);
        r1_xy <= PW'(i_x * i_y);
        r1_zz <= PW'(i_z * i_z);
        r1_wy <= PW'(i_w * i_y);
        r1_zx <= PW'(i_z * i_x);
    end

    // stage 2: sum terms, reduction, clamp test
    t_wide one_w;
    t_wide n_sr, n_cr, n_sy, n_cy, n_s, n_sp, n_sa;
    logic  n_clamp;

    assign one_w = t_wide'(1) <<< TWO_F;

    always_comb begin
        n_sr    = (r1_wx + r1_yz) <<< 1;
        n_cr    = one_w - ((r1_xx + r1_yy) <<< 1);
        n_sy    = (r1_wz + r1_xy) <<< 1;
        n_cy    = one_w - ((r1_yy + r1_zz) <<< 1);
        n_s     = (r1_wy - r1_zx) <<< 1;
        n_clamp = (n_s >= one_w) || (n_s <= -one_w);
        n_sp    = n_s >>> RED;
        n_sa    = n_sp[PW-1] ? -n_sp : n_sp;
    end

    logic  r2_vld, r2_clamp, r2_spos;
    t_wide r2_sr, r2_cr, r2_sy, r2_cy, r2_sp;
    t_sq   r2_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sr    <= n_sr >>> RED;
        r2_cr    <= n_cr >>> RED;
        r2_sy    <= n_sy >>> RED;
        r2_cy    <= n_cy >>> RED;
        r2_sp    <= n_sp;
        r2_clamp <= n_clamp;
        r2_spos  <= (n_s > 0);
        r2_rad   <= n_clamp ? '0
                    : (t_sq'(1) << (2 * G)) - t_sq'(n_sa[G:0]) * t_sq'(n_sa[G:0]);
    end

    // square root: four result bits per stage, restoring, pipelined
    t_sq           r_rem [STG+1];
    logic [RW-1:0] r_res [STG+1];
    logic          r_sv  [STG+1];
    t_wide         r_ssr [STG+1], r_scr [STG+1], r_ssy [STG+1], r_scy [STG+1];
    t_wide         r_ssp [STG+1];
    logic          r_scl [STG+1], r_sps [STG+1];

    always_comb begin
        r_rem[0] = r2_rad;
        r_res[0] = '0;
        r_sv[0]  = r2_vld;
        r_ssr[0] = r2_sr;
        r_scr[0] = r2_cr;
        r_ssy[0] = r2_sy;
        r_scy[0] = r2_cy;
        r_ssp[0] = r2_sp;
        r_scl[0] = r2_clamp;
        r_sps[0] = r2_spos;
    end

    for (genvar g = 0; g < STG; g++) begin : g_sq
        t_sq           n_rem;
        logic [RW-1:0] n_res;
        t_sq           trial;
        always_comb begin
            n_rem = r_rem[g];
            n_res = r_res[g];
            trial = '0;
            for (int b = 0; b < 4; b++) begin
                if (g * 4 + b < NSQ) begin
                    trial = (t_sq'(n_res) << (RW - (g * 4 + b)))
                            | (t_sq'(1) << (2 * (RW - 1 - (g * 4 + b))));
                    if (n_rem >= trial) begin
                        n_rem = n_rem - trial;
                        n_res[RW-1-(g*4+b)] = 1'b1;
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[g+1] <= 1'b0;
            end else begin
                r_sv[g+1] <= r_sv[g];
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[g+1] <= n_rem;
            r_res[g+1] <= n_res;
            r_ssr[g+1] <= r_ssr[g];
            r_scr[g+1] <= r_scr[g];
            r_ssy[g+1] <= r_ssy[g];
            r_scy[g+1] <= r_scy[g];
            r_ssp[g+1] <= r_ssp[g];
            r_scl[g+1] <= r_scl[g];
            r_sps[g+1] <= r_sps[g];
        end
    end

    // lane set-up: quadrant fold for each atan2, zero case marked
    q2e_pkg::t_lane n_lane [3];
    logic [2:0]     n_zero;
    t_wide          ly [3];
    t_wide          lx [3];

    always_comb begin
        ly[0] = r_ssy[STG];
        lx[0] = r_scy[STG];
        ly[1] = r_ssp[STG];
        lx[1] = t_wide'(r_res[STG]);
        ly[2] = r_ssr[STG];
        lx[2] = r_scr[STG];
        for (int k = 0; k < 3; k++) begin
            n_zero[k] = (lx[k] == '0) && (ly[k] == '0);
            if (lx[k][PW-1]) begin
                n_lane[k].x   = q2e_pkg::DAT_W'(-lx[k]);
                n_lane[k].y   = q2e_pkg::DAT_W'(-ly[k]);
                n_lane[k].acc = 32'h8000_0000;
            end else begin
                n_lane[k].x   = q2e_pkg::DAT_W'(lx[k]);
                n_lane[k].y   = q2e_pkg::DAT_W'(ly[k]);
                n_lane[k].acc = '0;
            end
        end
    end

    logic           r3_vld;
    q2e_pkg::t_lane r3_lane [3];
    logic [15:0]    r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r_sv[STG];
        end
    end

    // side bits: zero flags of the three lanes, clamp, pitch sign
    always_ff @(posedge i_clk) begin
        r3_lane <= n_lane;
        r3_side <= {11'd0, r_sps[STG], r_scl[STG], n_zero};
    end

    assign o_vld  = r3_vld;
    assign o_lane = r3_lane;
    assign o_side = r3_side;

endmodule

// ===== design/quaternion_to_euler_angles_unit.sv =====
// quaternion to zyx euler angles: front end, cordic cell chain, output register
// pipeline, in order:
//   products, sum terms, square root stages, lane set-up, one cell per cordic step, output
// throughput: one beat per cycle; busy stays low, the chain of cells takes a new beat each cycle
// reset: synchronous active-low i_rst_n clears all valid bits; no result strobes after reset
// the receiver cannot stall; each result shows for exactly one cycle under o_done
module quaternion_to_euler_angles_unit #(
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_done,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_roll_angle,
    output logic               o_pitch_clamped
);

    logic           c_vld  [CORDIC_STEPS+1];
    q2e_pkg::t_lane c_lane [CORDIC_STEPS+1][3];
    logic [15:0]    c_side [CORDIC_STEPS+1];

    assign busy = 1'b0;

    // front end
    q2e_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_vld   (c_vld[0]),
        .o_lane  (c_lane[0]),
        .o_side  (c_side[0])
    );

    // row of cordic cells
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        q2e_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (c_vld[i]),
            .i_lane  (c_lane[i]),
            .i_side  (c_side[i]),
            .o_vld   (c_vld[i+1]),
            .o_lane  (c_lane[i+1]),
            .o_side  (c_side[i+1])
        );
    end

    // output register
    logic        r_done, r_clamp;
    logic [15:0] r_yaw, r_pitch, r_roll;
    logic [15:0] fs;

    assign fs = c_side[CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= c_vld[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_yaw   <= fs[0] ? 16'd0 : q2e_pkg::to_out(c_lane[CORDIC_STEPS][0].acc);
        r_roll  <= fs[2] ? 16'd0 : q2e_pkg::to_out(c_lane[CORDIC_STEPS][2].acc);
        r_clamp <= fs[3];
        if (fs[3]) begin
            r_pitch <= fs[4] ? 16'sd16384 : -16'sd16384;
        end else begin
            r_pitch <= fs[1] ? 16'd0 : q2e_pkg::to_out(c_lane[CORDIC_STEPS][1].acc);
        end
    end

    assign o_done          = r_done;
    assign o_yaw_angle     = r_yaw;
    assign o_pitch_angle   = r_pitch;
    assign o_roll_angle    = r_roll;
    assign o_pitch_clamped = r_clamp;

    // a clamped pitch is always a quarter turn
    a_clamp_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_pitch_clamped |-> (o_pitch_angle == 16'sd16384 || o_pitch_angle == -16'sd16384))
        else $error("clamped pitch not a quarter turn");

    // never stalls the sender
    a_no_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");

    // no strobe right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("strobe after reset");

endmodule
